// File: hw/rtl/jhmi_pkg.sv
// shared types, constants and log2 helpers for the joint histogram mutual information core
package jhmi_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int MAX_BINS    = 64;
    localparam int SAMPLE_W    = 16;

    localparam int CFG_W    = 7;
    localparam int CFG_RESET = 16;
    localparam int CNT_W    = $clog2(MAX_SAMPLES) + 1;
    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int JADDR_W  = 2 * BIN_W;
    localparam int POS_W    = $clog2(CNT_W);
    localparam int FRAC_W   = 16;
    localparam int LOG_W    = POS_W + FRAC_W;
    localparam int PROD_W   = CNT_W + LOG_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int T_W      = SUM_W + 1;
    localparam int DIFF_W   = LOG_W + 2;
    localparam int JPROD_W  = CNT_W + 1 + DIFF_W;
    localparam int NBIN_W   = SAMPLE_W + 1 + BIN_W;
    localparam int DIVC_W   = $clog2(SUM_W + 1);
    localparam int MAGC_W   = 24;
    localparam int HX_W     = 20;
    localparam int MI_W     = 21;
    localparam int LN2_W    = 16;
    localparam logic [LN2_W-1:0] LN2_Q16 = 16'd45426;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_BIN_RD,
        OP_BIN_MUL,
        OP_BIN_DIV,
        OP_BIN_HRD,
        OP_BIN_HWR,
        OP_ENT_RD,
        OP_ENT_LOG,
        OP_ENT_MUL,
        OP_ENT_ACC,
        OP_JNT_RD,
        OP_JNT_LOG,
        OP_JNT_MUL,
        OP_JNT_ACC,
        OP_DIV_X,
        OP_WAIT_X,
        OP_DIV_Y,
        OP_WAIT_Y,
        OP_DIV_M,
        OP_WAIT_M,
        OP_SCALE,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic sample_last;
        logic ent_last;
        logic jnt_last;
        logic div_done;
    } status_t;

    typedef logic [FRAC_W-1:0] frac_tab_t [256];

    // floor(65536 * log2(1 + i/256)) by repeated squaring, evaluated at elaboration
    function automatic frac_tab_t build_frac();
        frac_tab_t          tab;
        logic [63:0]        m;
        logic [FRAC_W-1:0]  f;
        for (int i = 0; i < 256; i++)
        begin
            m = 64'(256 + i) << 22;
            f = '0;
            for (int k = 0; k < FRAC_W; k++)
            begin
                m = (m * m) >> 30;
                f = {f[FRAC_W-2:0], 1'b0};
                if (m >= 64'h8000_0000)
                begin
                    f[0] = 1'b1;
                    m    = m >> 1;
                end
            end
            tab[i] = f;
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TABLE = build_frac();

    // leading-one position in the integer part, table fraction from the next 8 bits
    function automatic logic [LOG_W-1:0] log2q(input logic [CNT_W-1:0] c);
        logic [POS_W-1:0] p;
        logic [CNT_W+7:0] sh;
        p = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (c[k])
            begin
                p = POS_W'(k);
            end
        end
        sh = {c, 8'b0} >> p;
        if (c == '0)
        begin
            return '0;
        end
        return {p, FRAC_TABLE[sh[7:0]]};
    endfunction

endpackage

// File: hw/rtl/joint_histogram_mutual_information_core.sv
// top level of the joint histogram mutual information core
//
// Samples (x_sample, y_sample) are taken one per clock while busy is low, at every
// edge with start high; up to 65536 are stored per set and later ones are dropped
// and flagged in status. A sample with last high closes the set and raises busy.
// The evaluation then clears the 4096-entry joint histogram, bins and counts every
// stored sample through the 6-step bin divider and the histogram read-modify-write,
// sums the marginal entropy terms, sweeps the joint histogram and runs three divides
// on the shared divider. The result appears for one cycle with done high and must be
// captured then; the receiver cannot stall it. bin_count is written through the cfg
// channel, which is always ready and should be used only while idle.
module joint_histogram_mutual_information_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [jhmi_pkg::SAMPLE_W-1:0]  x_sample,
    input  logic signed [jhmi_pkg::SAMPLE_W-1:0]  y_sample,
    input  logic                                  last,
    output logic                                  done,
    output logic [jhmi_pkg::HX_W-1:0]             entropy_x,
    output logic [jhmi_pkg::HX_W-1:0]             entropy_y,
    output logic signed [jhmi_pkg::MI_W-1:0]      mutual_info,
    output logic [jhmi_pkg::CNT_W-1:0]            sample_count,
    output logic                                  status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [jhmi_pkg::CFG_W-1:0]            cfg_data
);

    import jhmi_pkg::*;

    cmd_t    cmd;
    status_t dp_status;

    assign cfg_ready = 1'b1;

    jhmi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (dp_status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    jhmi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (dp_status),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .entropy_x    (entropy_x),
        .entropy_y    (entropy_y),
        .mutual_info  (mutual_info),
        .sample_count (sample_count),
        .status_flag  (status)
    );

endmodule

// File: hw/rtl/jhmi_ram.sv
// generic single-write, single-read ram with registered read data
module jhmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/jhmi_div.sv
// restoring divider, one quotient bit per cycle
module jhmi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [jhmi_pkg::SUM_W-1:0] dividend,
    input  logic [jhmi_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [jhmi_pkg::SUM_W-1:0] quotient
);

    import jhmi_pkg::*;

    logic [DIVC_W-1:0] cnt_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  q_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W+1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b0, dvs_reg};
    assign take   = ~trial[CNT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIVC_W'(SUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - DIVC_W'(1);
            done_reg <= (cnt_reg == DIVC_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], take};
            rem_reg <= take ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/jhmi_ctrl.sv
// sequencer for sample loading, histogram build and information evaluation
module jhmi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last,
    input  jhmi_pkg::status_t status,
    output jhmi_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    import jhmi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_BIN_RD,
        S_BIN_MUL,
        S_BIN_DIV,
        S_BIN_HRD,
        S_BIN_HWR,
        S_ENT_RD,
        S_ENT_LOG,
        S_ENT_MUL,
        S_ENT_ACC,
        S_JNT_RD,
        S_JNT_LOG,
        S_JNT_MUL,
        S_JNT_ACC,
        S_DIV_X,
        S_WAIT_X,
        S_DIV_Y,
        S_WAIT_Y,
        S_DIV_M,
        S_WAIT_M,
        S_SCALE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   load;

    assign load = start & ~busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (load && last) state_next = S_CLR;
            S_CLR:     if (status.clr_last) state_next = S_BIN_RD;
            S_BIN_RD:  state_next = S_BIN_MUL;
            S_BIN_MUL: state_next = S_BIN_DIV;
            S_BIN_DIV: if (status.div_last) state_next = S_BIN_HRD;
            S_BIN_HRD: state_next = S_BIN_HWR;
            S_BIN_HWR: state_next = status.sample_last ? S_ENT_RD : S_BIN_RD;
            S_ENT_RD:  state_next = S_ENT_LOG;
            S_ENT_LOG: state_next = S_ENT_MUL;
            S_ENT_MUL: state_next = S_ENT_ACC;
            S_ENT_ACC: state_next = status.ent_last ? S_JNT_RD : S_ENT_RD;
            S_JNT_RD:  state_next = S_JNT_LOG;
            S_JNT_LOG: state_next = S_JNT_MUL;
            S_JNT_MUL: state_next = S_JNT_ACC;
            S_JNT_ACC: state_next = status.jnt_last ? S_DIV_X : S_JNT_RD;
            S_DIV_X:   state_next = S_WAIT_X;
            S_WAIT_X:  if (status.div_done) state_next = S_DIV_Y;
            S_DIV_Y:   state_next = S_WAIT_Y;
            S_WAIT_Y:  if (status.div_done) state_next = S_DIV_M;
            S_DIV_M:   state_next = S_WAIT_M;
            S_WAIT_M:  if (status.div_done) state_next = S_SCALE;
            S_SCALE:   state_next = S_OUT;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load = load;
        unique case (state_reg)
            S_IDLE:    cmd.op = OP_NONE;
            S_CLR:     cmd.op = OP_CLR;
            S_BIN_RD:  cmd.op = OP_BIN_RD;
            S_BIN_MUL: cmd.op = OP_BIN_MUL;
            S_BIN_DIV: cmd.op = OP_BIN_DIV;
            S_BIN_HRD: cmd.op = OP_BIN_HRD;
            S_BIN_HWR: cmd.op = OP_BIN_HWR;
            S_ENT_RD:  cmd.op = OP_ENT_RD;
            S_ENT_LOG: cmd.op = OP_ENT_LOG;
            S_ENT_MUL: cmd.op = OP_ENT_MUL;
            S_ENT_ACC: cmd.op = OP_ENT_ACC;
            S_JNT_RD:  cmd.op = OP_JNT_RD;
            S_JNT_LOG: cmd.op = OP_JNT_LOG;
            S_JNT_MUL: cmd.op = OP_JNT_MUL;
            S_JNT_ACC: cmd.op = OP_JNT_ACC;
            S_DIV_X:   cmd.op = OP_DIV_X;
            S_WAIT_X:  cmd.op = OP_WAIT_X;
            S_DIV_Y:   cmd.op = OP_DIV_Y;
            S_WAIT_Y:  cmd.op = OP_WAIT_Y;
            S_DIV_M:   cmd.op = OP_DIV_M;
            S_WAIT_M:  cmd.op = OP_WAIT_M;
            S_SCALE:   cmd.op = OP_SCALE;
            S_OUT:     cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_reg == S_OUT);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: hw/rtl/jhmi_dp.sv
// sample stores, histograms, log and accumulate datapath, result registers
module jhmi_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jhmi_pkg::cmd_t                    cmd,
    output jhmi_pkg::status_t                 status,
    input  logic signed [jhmi_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [jhmi_pkg::SAMPLE_W-1:0] y_sample,
    input  logic                              cfg_we,
    input  logic [jhmi_pkg::CFG_W-1:0]        cfg_data,
    output logic [jhmi_pkg::HX_W-1:0]         entropy_x,
    output logic [jhmi_pkg::HX_W-1:0]         entropy_y,
    output logic signed [jhmi_pkg::MI_W-1:0]  mutual_info,
    output logic [jhmi_pkg::CNT_W-1:0]        sample_count,
    output logic                              status_flag
);

    import jhmi_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_BOT = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [HX_W:0]   H_MAX   = {1'b0, {HX_W{1'b1}}};
    localparam logic [MAGC_W-1:0] M_NEG = MAGC_W'(1) << (MI_W - 1);
    localparam logic [MAGC_W-1:0] M_POS = (MAGC_W'(1) << (MI_W - 1)) - MAGC_W'(1);

    // set state
    logic [CFG_W-1:0]           bin_count_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       dropped_reg;
    logic signed [SAMPLE_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [BIN_W-1:0]           b_last;
    logic                       full;

    // sequencing counters
    logic [JADDR_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [BIN_W-1:0]   ji_reg, jj_reg;
    logic [2:0]         dcnt_reg;

    // binning
    logic [NBIN_W-1:0]   nx_reg, ny_reg;
    logic [NBIN_W-2:0]   spx_reg, spy_reg;
    logic [BIN_W-1:0]    qx_reg, qy_reg;
    logic                flatx_reg, flaty_reg;
    logic [BIN_W-1:0]    bx, by;
    logic [SAMPLE_W:0]   dx, dy, spanx, spany;

    // accumulation
    logic [LOG_W-1:0]          ln_reg;
    logic [PROD_W-1:0]         nln_reg;
    logic [LOG_W-1:0]          lx_reg, ly_reg;
    logic [CNT_W-1:0]          cx_reg, cy_reg;
    logic [PROD_W-1:0]         px_reg, py_reg;
    logic [SUM_W-1:0]          sx_reg, sy_reg;
    logic signed [DIFF_W-1:0]  jd_reg;
    logic [CNT_W-1:0]          jc_reg;
    logic signed [JPROD_W-1:0] jp_reg;
    logic signed [T_W-1:0]     t_reg;

    // final divides and scaling
    logic [SUM_W-1:0]          qdx_reg, qdy_reg, qm_reg;
    logic                      mneg_reg;
    logic [LOG_W+LN2_W-1:0]    phx_reg, phy_reg;
    logic [MAGC_W+LN2_W-1:0]   pm_reg;
    logic signed [T_W-1:0]     num;
    logic                      num_neg;
    logic [T_W-1:0]            num_abs;
    logic [LOG_W-1:0]          hx_in, hy_in;
    logic [MAGC_W-1:0]         magc;
    logic [HX_W:0]             hxs, hys;
    logic [MAGC_W-1:0]         mm, mcap;

    // ram ports
    logic                st_we;
    logic [SAMPLE_W-1:0] x_rd, y_rd;
    logic                jt_we, xm_we, ym_we;
    logic [JADDR_W-1:0]  jt_waddr, jt_raddr;
    logic [BIN_W-1:0]    xm_waddr, ym_waddr, xm_raddr, ym_raddr;
    logic [CNT_W-1:0]    jt_wdata, xm_wdata, ym_wdata, jt_rd, xm_rd, ym_rd;

    logic [LOG_W-1:0]    lg_xm, lg_ym, lg_jt;

    logic                div_start, div_done;
    logic [SUM_W-1:0]    div_dividend, div_quot;

    always_comb
    begin
        if (bin_count_reg < CFG_W'(2))
        begin
            b_last = BIN_W'(1);
        end
        else if (bin_count_reg > CFG_W'(MAX_BINS))
        begin
            b_last = BIN_W'(MAX_BINS - 1);
        end
        else
        begin
            b_last = BIN_W'(bin_count_reg - CFG_W'(1));
        end
    end

    assign full  = (count_reg == CNT_W'(MAX_SAMPLES));
    assign st_we = cmd.load & ~full;

    assign bx = flatx_reg ? '0 : qx_reg;
    assign by = flaty_reg ? '0 : qy_reg;

    assign dx    = {x_rd[SAMPLE_W-1], x_rd} - {x_min_reg[SAMPLE_W-1], x_min_reg};
    assign dy    = {y_rd[SAMPLE_W-1], y_rd} - {y_min_reg[SAMPLE_W-1], y_min_reg};
    assign spanx = {x_max_reg[SAMPLE_W-1], x_max_reg} - {x_min_reg[SAMPLE_W-1], x_min_reg};
    assign spany = {y_max_reg[SAMPLE_W-1], y_max_reg} - {y_min_reg[SAMPLE_W-1], y_min_reg};

    // histogram ram addressing: clear sweep, per-sample increment, readout
    always_comb
    begin
        jt_we    = 1'b0;
        jt_waddr = {bx, by};
        jt_wdata = jt_rd + CNT_W'(1);
        xm_we    = 1'b0;
        xm_waddr = bx;
        xm_wdata = xm_rd + CNT_W'(1);
        ym_we    = 1'b0;
        ym_waddr = by;
        ym_wdata = ym_rd + CNT_W'(1);
        if (cmd.op == OP_CLR)
        begin
            jt_we    = 1'b1;
            jt_waddr = clr_addr_reg;
            jt_wdata = '0;
            xm_we    = (clr_addr_reg[JADDR_W-1:BIN_W] == '0);
            xm_waddr = clr_addr_reg[BIN_W-1:0];
            xm_wdata = '0;
            ym_we    = xm_we;
            ym_waddr = clr_addr_reg[BIN_W-1:0];
            ym_wdata = '0;
        end
        else if (cmd.op == OP_BIN_HWR)
        begin
            jt_we = 1'b1;
            xm_we = 1'b1;
            ym_we = 1'b1;
        end
    end

    assign jt_raddr = (cmd.op == OP_JNT_RD) ? {ji_reg, jj_reg} : {bx, by};
    assign xm_raddr = (cmd.op == OP_BIN_HRD) ? bx : ji_reg;
    assign ym_raddr = (cmd.op == OP_BIN_HRD) ? by :
                      ((cmd.op == OP_ENT_RD) ? ji_reg : jj_reg);

    jhmi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_x_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (x_sample),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (x_rd)
    );

    jhmi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_y_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (y_sample),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (y_rd)
    );

    jhmi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS * MAX_BINS)) u_joint (
        .clk   (clk),
        .we    (jt_we),
        .waddr (jt_waddr),
        .wdata (jt_wdata),
        .raddr (jt_raddr),
        .rdata (jt_rd)
    );

    jhmi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_x_marg (
        .clk   (clk),
        .we    (xm_we),
        .waddr (xm_waddr),
        .wdata (xm_wdata),
        .raddr (xm_raddr),
        .rdata (xm_rd)
    );

    jhmi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_y_marg (
        .clk   (clk),
        .we    (ym_we),
        .waddr (ym_waddr),
        .wdata (ym_wdata),
        .raddr (ym_raddr),
        .rdata (ym_rd)
    );

    assign lg_xm = log2q(xm_rd);
    assign lg_ym = log2q(ym_rd);
    assign lg_jt = log2q(jt_rd);

    // n*log2(n) + T, as magnitude and sign for the shared divider
    assign num     = $signed({{(T_W-PROD_W){1'b0}}, nln_reg}) + t_reg;
    assign num_neg = num[T_W-1];
    assign num_abs = num_neg ? T_W'(-num) : T_W'(num);

    assign div_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y) || (cmd.op == OP_DIV_M);

    always_comb
    begin
        case (cmd.op)
            OP_DIV_X: div_dividend = sx_reg;
            OP_DIV_Y: div_dividend = sy_reg;
            default:  div_dividend = num_abs[SUM_W-1:0];
        endcase
    end

    jhmi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign hx_in = (qdx_reg > SUM_W'(ln_reg)) ? '0 : ln_reg - qdx_reg[LOG_W-1:0];
    assign hy_in = (qdy_reg > SUM_W'(ln_reg)) ? '0 : ln_reg - qdy_reg[LOG_W-1:0];
    assign magc  = (qm_reg[SUM_W-1:MAGC_W] != '0) ? '1 : qm_reg[MAGC_W-1:0];

    assign hxs  = phx_reg[LOG_W+LN2_W-1:LN2_W];
    assign hys  = phy_reg[LOG_W+LN2_W-1:LN2_W];
    assign mm   = pm_reg[MAGC_W+LN2_W-1:LN2_W];
    assign mcap = mneg_reg ? ((mm > M_NEG) ? M_NEG : mm) : ((mm > M_POS) ? M_POS : mm);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= CFG_W'(CFG_RESET);
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            x_min_reg     <= S_TOP;
            y_min_reg     <= S_TOP;
            x_max_reg     <= S_BOT;
            y_max_reg     <= S_BOT;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            ji_reg        <= '0;
            jj_reg        <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bin_count_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                clr_addr_reg <= '0;
                idx_reg      <= '0;
                ji_reg       <= '0;
                jj_reg       <= '0;
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (x_sample < x_min_reg) x_min_reg <= x_sample;
                    if (x_sample > x_max_reg) x_max_reg <= x_sample;
                    if (y_sample < y_min_reg) y_min_reg <= y_sample;
                    if (y_sample > y_max_reg) y_max_reg <= y_sample;
                end
            end
            case (cmd.op)
                OP_CLR:     clr_addr_reg <= clr_addr_reg + JADDR_W'(1);
                OP_BIN_MUL: dcnt_reg <= '0;
                OP_BIN_DIV: dcnt_reg <= dcnt_reg + 3'd1;
                OP_BIN_HWR: idx_reg <= idx_reg + CNT_W'(1);
                OP_ENT_ACC: ji_reg <= status.ent_last ? '0 : ji_reg + BIN_W'(1);
                OP_JNT_ACC:
                begin
                    if (jj_reg == b_last)
                    begin
                        jj_reg <= '0;
                        ji_reg <= ji_reg + BIN_W'(1);
                    end
                    else
                    begin
                        jj_reg <= jj_reg + BIN_W'(1);
                    end
                end
                OP_OUT:
                begin
                    // set is done: back to an empty set, bin count kept
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                    x_min_reg   <= S_TOP;
                    y_min_reg   <= S_TOP;
                    x_max_reg   <= S_BOT;
                    y_max_reg   <= S_BOT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        nln_reg <= count_reg * ln_reg;
        case (cmd.op)
            OP_CLR:
            begin
                ln_reg <= log2q(count_reg);
                sx_reg <= '0;
                sy_reg <= '0;
                t_reg  <= '0;
            end
            OP_BIN_MUL:
            begin
                nx_reg    <= NBIN_W'(dx) * NBIN_W'(b_last);
                ny_reg    <= NBIN_W'(dy) * NBIN_W'(b_last);
                spx_reg   <= {spanx, {(BIN_W-1){1'b0}}};
                spy_reg   <= {spany, {(BIN_W-1){1'b0}}};
                qx_reg    <= '0;
                qy_reg    <= '0;
                flatx_reg <= (x_max_reg <= x_min_reg);
                flaty_reg <= (y_max_reg <= y_min_reg);
            end
            OP_BIN_DIV:
            begin
                // six-bit quotient, one bit per cycle for both channels
                if (nx_reg >= {1'b0, spx_reg})
                begin
                    nx_reg <= nx_reg - {1'b0, spx_reg};
                    qx_reg <= {qx_reg[BIN_W-2:0], 1'b1};
                end
                else
                begin
                    qx_reg <= {qx_reg[BIN_W-2:0], 1'b0};
                end
                if (ny_reg >= {1'b0, spy_reg})
                begin
                    ny_reg <= ny_reg - {1'b0, spy_reg};
                    qy_reg <= {qy_reg[BIN_W-2:0], 1'b1};
                end
                else
                begin
                    qy_reg <= {qy_reg[BIN_W-2:0], 1'b0};
                end
                spx_reg <= spx_reg >> 1;
                spy_reg <= spy_reg >> 1;
            end
            OP_ENT_LOG:
            begin
                lx_reg <= lg_xm;
                ly_reg <= lg_ym;
                cx_reg <= xm_rd;
                cy_reg <= ym_rd;
            end
            OP_ENT_MUL:
            begin
                px_reg <= cx_reg * lx_reg;
                py_reg <= cy_reg * ly_reg;
            end
            OP_ENT_ACC:
            begin
                sx_reg <= sx_reg + SUM_W'(px_reg);
                sy_reg <= sy_reg + SUM_W'(py_reg);
            end
            OP_JNT_LOG:
            begin
                jd_reg <= $signed({2'b0, lg_jt}) - $signed({2'b0, lg_xm})
                          - $signed({2'b0, lg_ym});
                jc_reg <= jt_rd;
            end
            OP_JNT_MUL: jp_reg <= $signed({1'b0, jc_reg}) * jd_reg;
            OP_JNT_ACC: t_reg <= t_reg + T_W'(jp_reg);
            OP_WAIT_X:  if (div_done) qdx_reg <= div_quot;
            OP_WAIT_Y:  if (div_done) qdy_reg <= div_quot;
            OP_DIV_M:   mneg_reg <= num_neg;
            OP_WAIT_M:  if (div_done) qm_reg <= div_quot;
            OP_SCALE:
            begin
                phx_reg <= hx_in * LN2_Q16;
                phy_reg <= hy_in * LN2_Q16;
                pm_reg  <= magc * LN2_Q16;
            end
            OP_OUT:
            begin
                entropy_x    <= (hxs > H_MAX) ? H_MAX[HX_W-1:0] : hxs[HX_W-1:0];
                entropy_y    <= (hys > H_MAX) ? H_MAX[HX_W-1:0] : hys[HX_W-1:0];
                mutual_info  <= mneg_reg ? MI_W'(-mcap[MI_W-1:0]) : mcap[MI_W-1:0];
                sample_count <= count_reg;
                status_flag  <= dropped_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.clr_last    = (clr_addr_reg == '1);
    assign status.div_last    = (dcnt_reg == 3'(BIN_W - 1));
    assign status.sample_last = (idx_reg == count_reg - CNT_W'(1));
    assign status.ent_last    = (ji_reg == b_last);
    assign status.jnt_last    = (ji_reg == b_last) && (jj_reg == b_last);
    assign status.div_done    = div_done;

endmodule
